>>> design/iss_pkg.sv
// ----------------------------------------------------------------------------
// iss_pkg: shared definitions for the indexed sequence store
// Command and status codes, payload structs and the control word that is
// broadcast to every storage cell.
// ----------------------------------------------------------------------------
package iss_pkg;

    localparam int CAPACITY_DEFAULT = 64;
    localparam int DATA_W           = 32;
    localparam int CMD_W            = 3;
    localparam int POS_W            = 8;
    localparam int STATUS_W         = 2;
    localparam int LENGTH_W         = 7;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_READ       = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INS_FRONT  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INS_BACK   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_INS_POS    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DELETE     = 3'd4;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

    // Value returned for any result that is not a valid read.
    localparam logic signed [DATA_W-1:0] READ_NONE = -32'sd1;

    // Cell operations.
    localparam logic [1:0] OP_HOLD   = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic signed [POS_W-1:0]  position;
        logic signed [DATA_W-1:0] data_in;
    } in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic [STATUS_W-1:0]      status;
        logic [LENGTH_W-1:0]      length;
    } out_t;

    typedef struct packed {
        logic [1:0]               op;
        logic signed [DATA_W-1:0] data;
    } cell_ctl_t;

endpackage

>>> design/iss_cell.sv
// ----------------------------------------------------------------------------
// iss_cell: one storage cell of the sequence chain
// Holds the value at one fixed position and takes its neighbor's value when
// an insert or delete shifts the sequence across it.
// ----------------------------------------------------------------------------
module iss_cell
    import iss_pkg::*;
#(
    parameter int IDX_W = 6,
    parameter int INDEX = 0
)
(
    input  logic                     clk,
    input  cell_ctl_t                ctl,
    input  logic [IDX_W-1:0]         idx,
    input  logic signed [DATA_W-1:0] left_value,
    input  logic signed [DATA_W-1:0] right_value,
    output logic signed [DATA_W-1:0] value,
    output logic signed [DATA_W-1:0] sel_value
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        unique case (ctl.op)
            OP_INSERT:
            begin
                if (MY_IDX == idx)
                begin
                    value_next = ctl.data;
                end
                else if (MY_IDX > idx)
                begin
                    value_next = left_value;
                end
            end
            OP_DELETE:
            begin
                if (MY_IDX >= idx)
                begin
                    value_next = right_value;
                end
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value     = value_reg;
    // Only the addressed cell puts its value on the read tree.
    assign sel_value = (MY_IDX == idx) ? value_reg : '0;

endmodule

>>> design/iss_read_tree.sv
// ----------------------------------------------------------------------------
// iss_read_tree: registered OR tree that collects the addressed cell
// Radix-4 reduction with a register at every level.
// ----------------------------------------------------------------------------
module iss_read_tree
    import iss_pkg::*;
#(
    parameter int N      = 64,
    parameter int LEVELS = 3
)
(
    input  logic                     clk,
    input  logic signed [DATA_W-1:0] leaf [N],
    output logic signed [DATA_W-1:0] result
);

    localparam int PAD = 1 << (2 * LEVELS);

    logic [DATA_W-1:0] padded [PAD];
    logic [DATA_W-1:0] node_reg [LEVELS][PAD/4];

    genvar k, l, j;
    generate
        for (k = 0; k < PAD; k++)
        begin : g_pad
            if (k < N)
            begin : g_used
                assign padded[k] = leaf[k];
            end
            else
            begin : g_zero
                assign padded[k] = '0;
            end
        end

        for (l = 0; l < LEVELS; l++)
        begin : g_level
            for (j = 0; j < (PAD >> (2 * (l + 1))); j++)
            begin : g_node
                if (l == 0)
                begin : g_first
                    always_ff @(posedge clk)
                    begin
                        node_reg[l][j] <= padded[4*j] | padded[4*j+1]
                                        | padded[4*j+2] | padded[4*j+3];
                    end
                end
                else
                begin : g_upper
                    always_ff @(posedge clk)
                    begin
                        node_reg[l][j] <= node_reg[l-1][4*j] | node_reg[l-1][4*j+1]
                                        | node_reg[l-1][4*j+2] | node_reg[l-1][4*j+3];
                    end
                end
            end
        end
    endgenerate

    assign result = node_reg[LEVELS-1][0];

endmodule

>>> design/indexed_sequence_store.sv
// ----------------------------------------------------------------------------
// indexed_sequence_store: ordered store of signed 32-bit values
// Chain of cells with positional insert, delete and read.
// ----------------------------------------------------------------------------
// The store keeps up to CAPACITY values packed from position 0 in a row of
// cells, one per position. Insert and delete commands are broadcast to every
// cell in the cycle the transaction is accepted; each cell compares its own
// position with the target and either keeps its value, loads the new one, or
// takes its left or right neighbor's value, and the result is registered and
// presented in the cycle after acceptance. A read sends the addressed cell's
// value through a registered radix-4 OR tree of ceil(log4(CAPACITY)) levels
// (3 for the default of 64), and the read result is registered once the tree
// has drained. One command is in flight at a time: a new transaction is
// accepted once the previous result has been taken, including in the same
// cycle the result is taken. Results that are not valid reads carry -1;
// status reports a bad position or a full store, and length gives the number
// of values held after the command.
// ----------------------------------------------------------------------------
module indexed_sequence_store
    import iss_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEFAULT
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data
);

    localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int CMP_W   = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
    localparam int LEVELS  = ($clog2(CAPACITY) + 1) / 2;
    localparam int WAIT_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    // Control state.
    logic              state_reg;
    logic              state_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [WAIT_W-1:0] wait_reg;
    logic [WAIT_W-1:0] wait_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    out_t              out_reg;
    out_t              out_next;

    logic accept;

    // Command decode.
    logic signed [CMP_W-1:0] pos_ext;
    logic signed [CMP_W-1:0] cnt_ext;
    logic                    pos_in_range;
    logic                    pos_past_end;
    logic                    full;
    logic [1:0]              dec_op;
    logic [IDX_W-1:0]        dec_idx;
    logic [STATUS_W-1:0]     dec_status;
    logic                    dec_read;

    // Cell chain.
    cell_ctl_t                cell_ctl;
    logic signed [DATA_W-1:0] cell_value [CAPACITY];
    logic signed [DATA_W-1:0] cell_sel [CAPACITY];
    logic signed [DATA_W-1:0] tree_result;

    assign accept = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);

    assign pos_ext = {{(CMP_W-POS_W){in_data.position[POS_W-1]}}, in_data.position};
    assign cnt_ext = {{(CMP_W-CNT_W){1'b0}}, count_reg};
    assign pos_in_range = !in_data.position[POS_W-1] && (pos_ext < cnt_ext);
    assign pos_past_end = pos_ext > cnt_ext;
    assign full = (count_reg == CNT_W'(CAPACITY));

    always_comb
    begin
        dec_op     = OP_HOLD;
        dec_idx    = '0;
        dec_status = ST_DONE;
        dec_read   = 1'b0;
        count_next = count_reg;
        unique case (in_data.cmd)
            CMD_READ:
            begin
                if (pos_in_range)
                begin
                    dec_read = 1'b1;
                    dec_idx  = pos_ext[IDX_W-1:0];
                end
                else
                begin
                    dec_status = ST_BADPOS;
                end
            end
            CMD_INS_FRONT:
            begin
                if (full)
                begin
                    dec_status = ST_FULL;
                end
                else
                begin
                    dec_op     = OP_INSERT;
                    count_next = count_reg + 1'b1;
                end
            end
            CMD_INS_BACK:
            begin
                if (full)
                begin
                    dec_status = ST_FULL;
                end
                else
                begin
                    dec_op     = OP_INSERT;
                    dec_idx    = count_reg[IDX_W-1:0];
                    count_next = count_reg + 1'b1;
                end
            end
            CMD_INS_POS:
            begin
                if (pos_past_end)
                begin
                    dec_status = ST_BADPOS;
                end
                else if (full)
                begin
                    dec_status = ST_FULL;
                end
                else
                begin
                    dec_op     = OP_INSERT;
                    // A negative position means the front.
                    dec_idx    = in_data.position[POS_W-1] ? '0 : pos_ext[IDX_W-1:0];
                    count_next = count_reg + 1'b1;
                end
            end
            CMD_DELETE:
            begin
                if (pos_in_range)
                begin
                    dec_op     = OP_DELETE;
                    dec_idx    = pos_ext[IDX_W-1:0];
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    dec_status = ST_BADPOS;
                end
            end
            default:
            begin
                dec_status = ST_BADPOS;
            end
        endcase
    end

    // Cells only move on the cycle a transaction is accepted.
    assign cell_ctl.op   = accept ? dec_op : OP_HOLD;
    assign cell_ctl.data = in_data.data_in;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic signed [DATA_W-1:0] left_v;
            logic signed [DATA_W-1:0] right_v;

            if (i == 0)
            begin : g_first
                assign left_v = cell_value[i];
            end
            else
            begin : g_mid_l
                assign left_v = cell_value[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_last
                assign right_v = cell_value[i];
            end
            else
            begin : g_mid_r
                assign right_v = cell_value[i+1];
            end

            iss_cell #(
                .IDX_W (IDX_W),
                .INDEX (i)
            ) u_cell (
                .clk         (clk),
                .ctl         (cell_ctl),
                .idx         (dec_idx),
                .left_value  (left_v),
                .right_value (right_v),
                .value       (cell_value[i]),
                .sel_value   (cell_sel[i])
            );
        end
    endgenerate

    iss_read_tree #(
        .N      (CAPACITY),
        .LEVELS (LEVELS)
    ) u_read_tree (
        .clk    (clk),
        .leaf   (cell_sel),
        .result (tree_result)
    );

    // Sequencing and result register. A valid read waits for the tree to
    // drain; every other command writes its result immediately.
    always_comb
    begin
        state_next     = state_reg;
        wait_next      = wait_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    out_next.status = dec_status;
                    out_next.length = LENGTH_W'(count_next);
                    if (dec_read)
                    begin
                        state_next = S_READ;
                        wait_next  = WAIT_W'(LEVELS - 1);
                    end
                    else
                    begin
                        out_next.read_value = READ_NONE;
                        out_valid_next      = 1'b1;
                    end
                end
            end
            S_READ:
            begin
                if (wait_reg == '0)
                begin
                    out_next.read_value = tree_result;
                    out_valid_next      = 1'b1;
                    state_next          = S_IDLE;
                end
                else
                begin
                    wait_next = wait_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wait_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wait_reg      <= wait_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

>>> verif/iss_sequence_checker.sv
// ----------------------------------------------------------------------------
// iss_sequence_checker: result checking for the indexed sequence store
// Watches both channels of the store. For every accepted command it works
// out the expected result from its own copy of the sequence, and it compares
// every accepted result field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module iss_sequence_checker
    import iss_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEFAULT
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic in_ready,
    input  in_t  in_data,
    input  logic out_valid,
    input  logic out_ready,
    input  out_t out_data,
    output int   errors,
    output int   pending
);

    // Shadow copy of the sequence and its length.
    logic signed [DATA_W-1:0] sequence_values [CAPACITY];
    int                       held;

    out_t expected_results [$];
    out_t want;
    bit   bad;

    // Puts a value at a position, moving the values at and after it back.
    function automatic logic [STATUS_W-1:0] place_value(input int at,
                                                        input logic signed [DATA_W-1:0] value);
        if (held >= CAPACITY)
            return ST_FULL;
        for (int i = held; i > at; i--)
            sequence_values[i] = sequence_values[i-1];
        sequence_values[at] = value;
        held++;
        return ST_DONE;
    endfunction

    // Applies one command to the shadow sequence and returns its result.
    function automatic out_t apply_command(input in_t c);
        out_t r;
        int   p;
        r.read_value = READ_NONE;
        r.status     = ST_DONE;
        p            = $signed(c.position);
        case (c.cmd)
            CMD_READ:
                if (p >= 0 && p < held)
                    r.read_value = sequence_values[p];
                else
                    r.status = ST_BADPOS;
            CMD_INS_FRONT:
                r.status = place_value(0, c.data_in);
            CMD_INS_BACK:
                r.status = place_value(held, c.data_in);
            CMD_INS_POS:
                if (p > held)
                    r.status = ST_BADPOS;
                else if (p <= 0)
                    r.status = place_value(0, c.data_in);
                else
                    r.status = place_value(p, c.data_in);
            CMD_DELETE:
                if (p >= 0 && p < held)
                begin
                    for (int i = p; i < held - 1; i++)
                        sequence_values[i] = sequence_values[i+1];
                    held--;
                end
                else
                begin
                    r.status = ST_BADPOS;
                end
            default:
                r.status = ST_BADPOS;
        endcase
        r.length = held[LENGTH_W-1:0];
        return r;
    endfunction

    task automatic note_mismatch(input string field, input longint exp_val,
                                 input longint act_val);
        $display("%0t: %s mismatch, expected %0d, actual %0d",
                 $time, field, exp_val, act_val);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_results.delete();
            held    = 0;
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            // The result leaving now always belongs to an older command, so it
            // is matched before this cycle's command is predicted.
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %p",
                             $time, out_data);
                    errors <= errors + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    bad  = 1'b0;
                    if (out_data.read_value !== want.read_value)
                    begin
                        bad = 1'b1;
                        note_mismatch("read_value", want.read_value,
                                      $signed(out_data.read_value));
                    end
                    if (out_data.status !== want.status)
                    begin
                        bad = 1'b1;
                        note_mismatch("status", want.status, out_data.status);
                    end
                    if (out_data.length !== want.length)
                    begin
                        bad = 1'b1;
                        note_mismatch("length", want.length, out_data.length);
                    end
                    if (bad)
                        errors <= errors + 1;
                end
            end
            if (in_valid && in_ready)
                expected_results.push_back(apply_command(in_data));
            pending <= expected_results.size();
        end
    end

endmodule

>>> verif/tb_indexed_sequence_store.sv
// ----------------------------------------------------------------------------
// tb_indexed_sequence_store: testbench for the indexed sequence store
// Drives a directed set of commands that covers the corner cases, then
// phases of random commands that grow, shrink and churn the sequence, with
// random idle cycles on both channels and one long output stall. A separate
// checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_indexed_sequence_store;
    import iss_pkg::*;

    localparam int HALF_PERIOD    = 5;
    localparam int RESET_CYCLES   = 6;
    localparam int RANDOM_ITEMS   = 1425;
    localparam int PHASE_ITEMS    = 100;
    localparam int MAX_GAP        = 9;
    localparam int LONG_HOLD      = 150;
    localparam int HOLD_AT_RESULT = 300;
    localparam int DRAIN_CYCLES   = 16;
    localparam int STALL_LIMIT    = 2000;

    // Codes above the last defined command are unused; the store must
    // reject them with a bad-position status.
    localparam logic [CMD_W-1:0] CMD_LAST_CODE = '1;

    // Random phases: grow the sequence until it fills, shrink it until it
    // empties, then mix everything.
    typedef enum int {PHASE_GROW, PHASE_SHRINK, PHASE_MIXED} phase_t;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_t  in_data;
    logic out_valid;
    logic out_ready;
    out_t out_data;

    int errors;
    int pending;

    // Length reported by the most recent result. With one command in flight
    // this is at most one command behind, which is close enough to steer
    // positions toward the interesting range.
    int held_seen     = 0;
    int results_taken = 0;
    int stall_cycles  = 0;

    // When set, neither side inserts idle cycles.
    bit steady = 1'b0;

    always #HALF_PERIOD clk = ~clk;

    indexed_sequence_store i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    iss_sequence_checker u_checker
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .errors    (errors),
        .pending   (pending)
    );

    // Track the reported length and how many results have been taken.
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            held_seen     <= int'(out_data.length);
            results_taken <= results_taken + 1;
        end
    end

    // Watchdog: a run is hung once the count of cycles in which no transaction
    // completes on either channel reaches STALL_LIMIT. The limit covers the long
    // output hold plus the worst idle gaps and the read latency many times over.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic in_t make_command(input logic [CMD_W-1:0] cmd, input int pos,
                                         input logic signed [DATA_W-1:0] value);
        in_t c;
        c.cmd      = cmd;
        c.position = POS_W'(pos);
        c.data_in  = value;
        return c;
    endfunction

    // Draws a random command. Most positions land between 0 and the current
    // length, so reads and deletes usually hit a stored value, while the rest
    // probe negative positions, positions just past the end and the whole
    // 8-bit range.
    function automatic in_t random_command(input phase_t phase);
        in_t c;
        int  roll;
        int  ins_w;
        int  del_w;
        case (phase)
            PHASE_GROW:   begin ins_w = 72; del_w = 10; end
            PHASE_SHRINK: begin ins_w = 15; del_w = 62; end
            default:      begin ins_w = 40; del_w = 30; end
        endcase

        roll = $urandom_range(0, 99);
        if (roll < ins_w)
        begin
            case ($urandom_range(0, 2))
                0:       c.cmd = CMD_INS_FRONT;
                1:       c.cmd = CMD_INS_BACK;
                default: c.cmd = CMD_INS_POS;
            endcase
        end
        else if (roll < ins_w + del_w)
            c.cmd = CMD_DELETE;
        else if (roll < 97)
            c.cmd = CMD_READ;
        else
            c.cmd = CMD_W'($urandom_range(CMD_DELETE + 1, CMD_LAST_CODE));

        roll = $urandom_range(0, 99);
        if (roll < 70)
            c.position = POS_W'($urandom_range(0, held_seen));
        else if (roll < 80)
            c.position = POS_W'(-int'($urandom_range(1, 128)));
        else if (roll < 90)
            c.position = POS_W'(held_seen + int'($urandom_range(1, 3)));
        else
            c.position = POS_W'($urandom);

        roll = $urandom_range(0, 99);
        if (roll < 3)
            c.data_in = {1'b0, {(DATA_W-1){1'b1}}};
        else if (roll < 6)
            c.data_in = {1'b1, {(DATA_W-1){1'b0}}};
        else if (roll < 8)
            c.data_in = '1;
        else if (roll < 10)
            c.data_in = '0;
        else
            c.data_in = $urandom;
        return c;
    endfunction

    // Offers one command after a random idle gap and returns at the edge
    // where it is accepted. A zero gap keeps valid high straight into the
    // next command, so valid is never dropped and raised in one step.
    task automatic offer(input in_t item);
        int gap;
        gap = steady ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_data  <= item;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!(in_valid && in_ready))
            @(posedge clk);
    endtask

    // Result side. Ready is raised after a random gap and held until a
    // result is taken. Once, after HOLD_AT_RESULT results, ready stays low
    // for a long stretch while the sender keeps a command waiting, so the
    // store backs up and must hold off its input.
    initial
    begin : result_taker
        int gap;
        bit held_long;
        held_long = 1'b0;
        out_ready <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        forever
        begin
            if (!held_long && results_taken >= HOLD_AT_RESULT)
            begin
                gap       = LONG_HOLD;
                held_long = 1'b1;
            end
            else
            begin
                gap = steady ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!(out_valid && out_ready))
                @(posedge clk);
        end
    end

    initial
    begin : command_source
        phase_t phase;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_data  <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. The store starts empty, so reads, deletes and a
        // positional insert past the end must all be rejected.
        offer(make_command(CMD_READ, 0, 32'sd5));
        offer(make_command(CMD_DELETE, 0, 32'sd5));
        offer(make_command(CMD_INS_POS, 1, 32'sd7));

        // Build a short sequence using every insert flavor and the extremes
        // of the data field. The most negative position acts as the front,
        // and a position equal to the length acts as the back.
        offer(make_command(CMD_INS_FRONT, 0, {1'b0, {(DATA_W-1){1'b1}}}));
        offer(make_command(CMD_INS_BACK, 0, {1'b1, {(DATA_W-1){1'b0}}}));
        offer(make_command(CMD_INS_POS, -128, -32'sd1));
        offer(make_command(CMD_INS_POS, -1, 32'sd0));
        offer(make_command(CMD_INS_POS, 4, 32'sd1234));
        offer(make_command(CMD_INS_POS, 2, 32'h5555_5555));
        offer(make_command(CMD_INS_POS, 127, 32'hAAAA_AAAA));

        // Reads at both ends, at the length, and at out-of-range positions.
        offer(make_command(CMD_READ, 0, '0));
        offer(make_command(CMD_READ, 5, '1));
        offer(make_command(CMD_READ, 6, '0));
        offer(make_command(CMD_READ, -1, '0));
        offer(make_command(CMD_READ, 127, '0));

        // Deletes at the length, the back, the front and the middle, then a
        // negative one, with a read to confirm how the values closed up.
        offer(make_command(CMD_DELETE, 6, '0));
        offer(make_command(CMD_DELETE, 5, '0));
        offer(make_command(CMD_DELETE, 0, '0));
        offer(make_command(CMD_DELETE, 1, '0));
        offer(make_command(CMD_DELETE, -128, '0));
        offer(make_command(CMD_READ, 1, '0));

        // The unused command codes change nothing.
        for (int code = CMD_DELETE + 1; code <= CMD_LAST_CODE; code++)
            offer(make_command(CMD_W'(code), 0, 32'sd99));

        // Random part. The grow phases are long enough to fill the store,
        // so inserts into a full store are exercised every cycle of phases.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            phase  = phase_t'((i / PHASE_ITEMS) % 3);
            steady = ((i / 70) % 5) == 4;
            offer(random_command(phase));
        end
        in_valid <= 1'b0;
        steady   = 1'b0;

        // Let the last transaction reach the checker, wait for every result,
        // then give the store a few more cycles in case anything stray comes
        // out. The watchdog bounds these waits.
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
